@@ hw/rtl/lcig_pkg.sv @@
// Package for the linear chirp I/Q generator: widths, reset values,
// configuration register indexes and the control struct of the sample pipeline.
// No dependencies.
`default_nettype none

package lcig_pkg;

  // Default geometry of the generator
  localparam int TABLE_ADDR_BITS_DEF = 12;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COUNT_BITS_DEF      = 24;

  // Fixed word widths
  localparam int PHASE_W       = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_REG_W     = 24;
  localparam int AMP_W         = 16;
  localparam int AMP_FRAC_BITS = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_RATE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd3;

  // Register reset values
  localparam logic [PHASE_W-1:0]   START_STEP_RST   = '0;
  localparam logic [PHASE_W-1:0]   HALF_RATE_RST    = '0;
  localparam logic [CNT_REG_W-1:0] SAMPLE_COUNT_RST = 24'd1024;
  localparam logic [AMP_W-1:0]     AMPLITUDE_RST    = 16'd32768;

  // Per-sample control carried alongside the table lookup
  typedef struct packed {
    logic sin_neg;
    logic cos_neg;
    logic last;
  } lcig_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/lcig_in_if.sv @@
// Request channel of the chirp generator: valid/ready plus the restart flag.
// Depends on nothing.
`default_nettype none

interface lcig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcig_out_if.sv @@
// Result channel of the chirp generator: valid/ready plus one I/Q sample.
// Depends on lcig_pkg for default widths.
`default_nettype none

interface lcig_out_if #(
  parameter int SAMPLE_BITS = lcig_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = lcig_pkg::COUNT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] i_sample;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic [COUNT_BITS-1:0]         sample_index;
  logic                          last;

  modport source (output valid, output i_sample, output q_sample,
                  output sample_index, output last, input ready);
  modport sink   (input valid, input i_sample, input q_sample,
                  input sample_index, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/linear_chirp_iq_generator_core.sv @@
// Linear FM chirp I/Q generator, top level: configuration registers, pipeline
// control, phase generator, sine ROM and two scalers.
// Depends on lcig_pkg, lcig_in_if, lcig_out_if, lcig_phase_gen, lcig_sine_rom, lcig_scale.
//
//   Channel  Direction  Signals                                        Handshake
//   in_if    sink       restart                                        valid/ready
//   out_if   source     i_sample, q_sample, sample_index, last         valid/ready
//   cfg_*    write      cfg_we, cfg_index, cfg_wdata                   we only
//
// One sample per clock while out_if.ready stays high; a request's result is valid
// once it has passed the ROM read register, then the product register.
// Phase, step and counter update on each accepted request, so requests may follow
// every cycle. Reset (rst_n low, synchronous) clears state and pipeline valids
// and loads the register defaults. When out_if.ready is low the result holds;
// in_if.ready drops only when both pipeline stages hold samples.
`default_nettype none

module linear_chirp_iq_generator_core #(
  parameter int TABLE_ADDR_BITS = lcig_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = lcig_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS      = lcig_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lcig_in_if.sink                                 in_if,
  lcig_out_if.source                              out_if,
  input  wire logic                               cfg_we,
  input  wire logic [lcig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcig_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PW = lcig_pkg::PHASE_W;

  // Configuration registers
  logic [PW-1:0]                    start_step_r;
  logic [PW-1:0]                    half_rate_r;
  logic [lcig_pkg::CNT_REG_W-1:0]   sample_count_r;
  logic [lcig_pkg::AMP_W-1:0]       amplitude_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r   <= lcig_pkg::START_STEP_RST;
      half_rate_r    <= lcig_pkg::HALF_RATE_RST;
      sample_count_r <= lcig_pkg::SAMPLE_COUNT_RST;
      amplitude_r    <= lcig_pkg::AMPLITUDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcig_pkg::REG_START_STEP:   start_step_r   <= cfg_wdata[PW-1:0];
        lcig_pkg::REG_HALF_RATE:    half_rate_r    <= cfg_wdata[PW-1:0];
        lcig_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[lcig_pkg::CNT_REG_W-1:0];
        lcig_pkg::REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[lcig_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: each stage moves when the one after it has room
  logic s1_valid_r, s2_valid_r;
  logic en1, en2, accept;

  always_comb begin
    en2          = !s2_valid_r || out_if.ready;
    en1          = !s1_valid_r || en2;
    in_if.ready  = en1;
    accept       = in_if.valid && en1;
    out_if.valid = s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= accept;
      if (en2) s2_valid_r <= s1_valid_r;
    end
  end

  // Phase generation at request accept
  logic [TABLE_ADDR_BITS-2:0] sin_idx, cos_idx;
  lcig_pkg::lcig_ctl_t        ctl;
  logic [COUNT_BITS-1:0]      sample_index;

  lcig_phase_gen #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .restart      (in_if.restart),
    .start_step   (start_step_r),
    .half_rate    (half_rate_r),
    .sample_count (sample_count_r),
    .sin_idx      (sin_idx),
    .cos_idx      (cos_idx),
    .ctl          (ctl),
    .sample_index (sample_index)
  );

  // Stage 1: table read, control and index alongside
  logic [SAMPLE_BITS-2:0] sin_val, cos_val;
  lcig_pkg::lcig_ctl_t    s1_ctl_r;
  logic [COUNT_BITS-1:0]  s1_index_r;

  lcig_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .en      (en1),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctl_r   <= ctl;
      s1_index_r <= sample_index;
    end
  end

  // Stage 2: scaled products, which are the output register
  logic                  s2_last_r;
  logic [COUNT_BITS-1:0] s2_index_r;

  lcig_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_i (
    .clk       (clk),
    .en        (en2),
    .neg       (s1_ctl_r.cos_neg),
    .tab       (cos_val),
    .amplitude (amplitude_r),
    .sample    (out_if.i_sample)
  );

  lcig_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_q (
    .clk       (clk),
    .en        (en2),
    .neg       (s1_ctl_r.sin_neg),
    .tab       (sin_val),
    .amplitude (amplitude_r),
    .sample    (out_if.q_sample)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_last_r  <= s1_ctl_r.last;
      s2_index_r <= s1_index_r;
    end
  end

  assign out_if.sample_index = s2_index_r;
  assign out_if.last         = s2_last_r;

  // A restart request lands in stage 1 as sample zero
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.restart |=> s1_valid_r && s1_index_r == '0)
    else $error("restart did not begin at sample zero");

  // An empty first stage never blocks requests
  a_s1_room: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_if.ready)
    else $error("request blocked with stage 1 empty");

  // Stage 1 contents reach the output once the output stage has room
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && en2 |=> out_if.valid)
    else $error("stage 1 sample lost on its way to the output");

endmodule

`default_nettype wire

@@ hw/rtl/lcig_phase_gen.sv @@
// Chirp phase generator: phase accumulator, step register and sample counter,
// producing quarter-wave table addresses for sine and cosine.
// Depends on lcig_pkg.
`default_nettype none

module lcig_phase_gen #(
  parameter int TABLE_ADDR_BITS = lcig_pkg::TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = lcig_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               accept,
  input  wire logic                               restart,
  input  wire logic [lcig_pkg::PHASE_W-1:0]       start_step,
  input  wire logic [lcig_pkg::PHASE_W-1:0]       half_rate,
  input  wire logic [lcig_pkg::CNT_REG_W-1:0]     sample_count,
  output logic      [TABLE_ADDR_BITS-2:0]         sin_idx,
  output logic      [TABLE_ADDR_BITS-2:0]         cos_idx,
  output lcig_pkg::lcig_ctl_t                     ctl,
  output logic      [COUNT_BITS-1:0]              sample_index
);

  localparam int PW    = lcig_pkg::PHASE_W;
  localparam int IDX_W = TABLE_ADDR_BITS - 1;
  localparam int R_W   = TABLE_ADDR_BITS - 2;
  localparam int CMP_W = (COUNT_BITS + 1 > lcig_pkg::CNT_REG_W) ?
                         COUNT_BITS + 1 : lcig_pkg::CNT_REG_W;
  localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1) << R_W;

  logic [PW-1:0]         acc_r, acc_nxt;
  logic [PW-1:0]         step_r, step_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                       chirp_start;
  logic [PW-1:0]              eff_acc, eff_step;
  logic [COUNT_BITS-1:0]      eff_cnt;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]                 sin_q, cos_q;
  logic [R_W-1:0]             rem;
  logic [CMP_W-1:0]           cnt_plus;
  logic                       fin;

  // Chirp start reloads phase, step and counter before the sample goes out
  always_comb begin
    chirp_start = restart || (cnt_r == '0);
    eff_acc     = chirp_start ? '0 : acc_r;
    eff_step    = chirp_start ? (start_step + half_rate) : step_r;
    eff_cnt     = chirp_start ? '0 : cnt_r;
  end

  // Quarter-wave address folding; cosine sits one quadrant ahead
  always_comb begin
    addr    = eff_acc[PW-1 -: TABLE_ADDR_BITS];
    sin_q   = addr[TABLE_ADDR_BITS-1 -: 2];
    cos_q   = sin_q + 2'd1;
    rem     = addr[R_W-1:0];
    sin_idx = sin_q[0] ? (QUARTER - {1'b0, rem}) : {1'b0, rem};
    cos_idx = cos_q[0] ? (QUARTER - {1'b0, rem}) : {1'b0, rem};
  end

  // End of chirp: count reached, or the counter is full
  always_comb begin
    cnt_plus     = CMP_W'(eff_cnt) + CMP_W'(1);
    fin          = (cnt_plus >= CMP_W'(sample_count)) || (&eff_cnt);
    ctl.sin_neg  = sin_q[1];
    ctl.cos_neg  = cos_q[1];
    ctl.last     = fin;
    sample_index = eff_cnt;
  end

  // State advance for the next sample
  always_comb begin
    acc_nxt  = acc_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (fin) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt  = eff_cnt + COUNT_BITS'(1);
        acc_nxt  = eff_acc + eff_step;
        step_nxt = eff_step + {half_rate[PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Counter advances by one within a chirp and wraps to zero after its last sample
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !ctl.last |=> cnt_r == $past(sample_index) + COUNT_BITS'(1))
    else $error("sample counter did not advance");

  a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.last |=> cnt_r == '0)
    else $error("sample counter did not wrap after last sample");

endmodule

`default_nettype wire

@@ hw/rtl/lcig_sine_rom.sv @@
// Quarter-wave sine ROM with two registered read ports (sine and cosine).
// Contents are computed at elaboration. Depends on nothing beyond its parameters.
`default_nettype none

module lcig_sine_rom #(
  parameter int TABLE_ADDR_BITS = 12,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [TABLE_ADDR_BITS-2:0] sin_idx,
  input  wire logic [TABLE_ADDR_BITS-2:0] cos_idx,
  output logic      [SAMPLE_BITS-2:0]     sin_val,
  output logic      [SAMPLE_BITS-2:0]     cos_val
);

  localparam int  DEPTH = (1 << (TABLE_ADDR_BITS - 2)) + 1;
  localparam int  VAL_W = SAMPLE_BITS - 1;
  localparam real PI    = 3.14159265358979323846;

  typedef logic [VAL_W-1:0] rom_arr_t [DEPTH];

  // round(peak * sin(pi * r / 2^(addr_bits-1))), ties away from zero
  function automatic rom_arr_t build_rom();
    rom_arr_t t;
    real      peak;
    real      ang;
    peak = real'((1 << (SAMPLE_BITS - 1)) - 1);
    for (int r = 0; r < DEPTH; r++) begin
      ang  = PI * real'(r) * (2.0 ** (1 - TABLE_ADDR_BITS));
      t[r] = VAL_W'(int'(peak * $sin(ang)));
    end
    return t;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [VAL_W-1:0] sin_r, cos_r;

  // Synchronous reads, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= ROM[sin_idx];
      cos_r <= ROM[cos_idx];
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

`default_nettype wire

@@ hw/rtl/lcig_scale.sv @@
// Amplitude scaling of one table value: sign, multiply, register, then
// arithmetic shift and saturation. Depends on lcig_pkg.
`default_nettype none

module lcig_scale #(
  parameter int SAMPLE_BITS = lcig_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic                            neg,
  input  wire logic [SAMPLE_BITS-2:0]          tab,
  input  wire logic [lcig_pkg::AMP_W-1:0]      amplitude,
  output logic signed [SAMPLE_BITS-1:0]        sample
);

  localparam int PROD_W = SAMPLE_BITS + lcig_pkg::AMP_W + 1;
  localparam logic signed [PROD_W-1:0] SMP_MAX =
    PROD_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SMP_MIN = -SMP_MAX - PROD_W'(1);

  logic signed [SAMPLE_BITS:0]         tab_s;
  logic signed [lcig_pkg::AMP_W:0]     amp_s;
  logic signed [PROD_W-1:0]            prod_r, prod_nxt;
  logic signed [PROD_W-1:0]            shifted;

  // Signed table value times gain
  always_comb begin
    tab_s    = neg ? -$signed({2'b00, tab}) : $signed({2'b00, tab});
    amp_s    = $signed({1'b0, amplitude});
    prod_nxt = tab_s * amp_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // Floor shift back to sample scale, clamp to the signed sample range
  always_comb begin
    shifted = prod_r >>> lcig_pkg::AMP_FRAC_BITS;
    if (shifted > SMP_MAX) begin
      sample = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (shifted < SMP_MIN) begin
      sample = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      sample = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire
